// ===== design/owm_pkg.sv =====
`default_nettype none
package owm_pkg;

	// timer and register widths
	localparam int TIMER_BITS = 10;
	localparam int CFG_W = 10;
	localparam int NUM_REGS = 7;
	localparam int ADDR_W = 5;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

	// register indexes
	localparam logic [2:0] REG_RESET_LOW = 3'd0;
	localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [2:0] REG_RESET_TAIL = 3'd2;
	localparam logic [2:0] REG_SLOT_START = 3'd3;
	localparam logic [2:0] REG_WRITE_HOLD = 3'd4;
	localparam logic [2:0] REG_READ_SAMPLE = 3'd5;
	localparam logic [2:0] REG_READ_TAIL = 3'd6;

	// register reset values
	localparam logic [CFG_W-1:0] DEF_RESET_LOW = 10'd500;
	localparam logic [CFG_W-1:0] DEF_PRESENCE_WAIT = 10'd70;
	localparam logic [CFG_W-1:0] DEF_RESET_TAIL = 10'd500;
	localparam logic [CFG_W-1:0] DEF_SLOT_START = 10'd5;
	localparam logic [CFG_W-1:0] DEF_WRITE_HOLD = 10'd50;
	localparam logic [CFG_W-1:0] DEF_READ_SAMPLE = 10'd5;
	localparam logic [CFG_W-1:0] DEF_READ_TAIL = 10'd50;

	// operation codes
	localparam logic [2:0] OP_RESET = 3'd0;
	localparam logic [2:0] OP_WRITE_BIT = 3'd1;
	localparam logic [2:0] OP_READ_BIT = 3'd2;
	localparam logic [2:0] OP_WRITE_BYTE = 3'd3;
	localparam logic [2:0] OP_READ_BYTE = 3'd4;

	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_RST_LOW = 4'd1,
		PH_RST_WAIT = 4'd2,
		PH_RST_TAIL = 4'd3,
		PH_WR_START = 4'd4,
		PH_WR_HOLD = 4'd5,
		PH_RD_START = 4'd6,
		PH_RD_WAIT = 4'd7,
		PH_RD_TAIL = 4'd8
	} phase_t;

	typedef struct packed {
		logic cmd_valid;
		logic [2:0] operation;
		logic [7:0] write_data;
		logic line_level;
	} in_item_t;

	typedef struct packed {
		logic line_release;
		logic busy_res;
		logic done_res;
		logic presence_line;
		logic [7:0] read_byte;
	} out_item_t;

endpackage
`default_nettype wire

// ===== design/one_wire_bus_master_core.sv =====
// 1-Wire bus master core, one item per time tick
//
// item channel (item_valid/item_ready/item): each accepted item is one tick.
// it carries an optional command (reset, write bit, read bit, write byte,
// read byte), the byte to send and the sampled level of the data line.
// result channel (result_valid/result_ready/result): exactly one result per
// item, in order: the line drive for that tick, busy, done, the latched
// presence level and the received data on the finishing tick.
// slot timings come from seven 10-bit tick count registers on the APB port;
// the user must write them only while no item is in flight; the block itself
// does not enforce this. an item is registered at the input, then its state
// update and result are computed in one pass into the result register.
// throughput: one item per cycle unless the receiver stalls; the timer/phase
// state is updated combinationally, so consecutive ticks follow back to back.
// when the receiver stalls the result register holds; the input register
// keeps one more item and then item_ready drops until the result is taken.
// reset clears the phase to idle, the presence latch to one and loads the
// timing registers with their default tick counts.
`default_nettype none
module one_wire_bus_master_core
	import owm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire in_item_t          item,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output out_item_t              result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	logic [CFG_W-1:0] cfg_q [NUM_REGS];
	logic [2:0] reg_idx;

	in_item_t item_s1;
	logic valid_s1;
	logic advance;

	phase_t phase_q, ph;
	logic [TIMER_BITS-1:0] timer_q, tm;
	logic [3:0] bit_count_q, bc;
	logic [7:0] shift_q, sb;
	logic [2:0] op_q, aop;
	logic presence_q, pres;
	out_item_t res;
	logic fin;

	function automatic logic [TIMER_BITS-1:0] load_ticks(input logic [CFG_W-1:0] v);
		logic [16:0] vx;
		logic [TIMER_BITS-1:0] r;
		vx = 17'(v);
		if (vx == 17'd0)
			r = TIMER_BITS'(1);
		else if (vx > 17'(TIMER_MAX))
			r = TIMER_MAX;
		else
			r = TIMER_BITS'(vx);
		return r;
	endfunction

	// configuration port
	assign pready = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_RESET_LOW] <= DEF_RESET_LOW;
			cfg_q[REG_PRESENCE_WAIT] <= DEF_PRESENCE_WAIT;
			cfg_q[REG_RESET_TAIL] <= DEF_RESET_TAIL;
			cfg_q[REG_SLOT_START] <= DEF_SLOT_START;
			cfg_q[REG_WRITE_HOLD] <= DEF_WRITE_HOLD;
			cfg_q[REG_READ_SAMPLE] <= DEF_READ_SAMPLE;
			cfg_q[REG_READ_TAIL] <= DEF_READ_TAIL;
		end else if (psel && penable && pwrite && 32'(reg_idx) < NUM_REGS) begin
			cfg_q[reg_idx] <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (32'(reg_idx) < NUM_REGS && paddr[1:0] == 2'b00)
			prdata = 32'(cfg_q[reg_idx]);
	end

	// input register and handshake
	assign advance = valid_s1 && (!result_valid || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (item_ready)
			valid_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid)
			item_s1 <= item;
	end

	// one tick of the bus sequencer
	always_comb begin
		ph = phase_q;
		tm = timer_q;
		bc = bit_count_q;
		sb = shift_q;
		aop = op_q;
		pres = presence_q;
		fin = 1'b0;
		res = '0;
		res.line_release = 1'b1;

		// command start
		if (ph == PH_IDLE && item_s1.cmd_valid && item_s1.operation <= OP_READ_BYTE) begin
			aop = item_s1.operation;
			case (item_s1.operation)
				OP_RESET: begin
					ph = PH_RST_LOW;
					tm = load_ticks(cfg_q[REG_RESET_LOW]);
				end
				OP_WRITE_BIT: begin
					sb = {7'd0, item_s1.write_data[0]};
					bc = 4'd1;
					ph = PH_WR_START;
					tm = load_ticks(cfg_q[REG_SLOT_START]);
				end
				OP_WRITE_BYTE: begin
					sb = item_s1.write_data;
					bc = 4'd8;
					ph = PH_WR_START;
					tm = load_ticks(cfg_q[REG_SLOT_START]);
				end
				OP_READ_BIT: begin
					sb = '0;
					bc = 4'd1;
					ph = PH_RD_START;
					tm = load_ticks(cfg_q[REG_SLOT_START]);
				end
				default: begin
					sb = '0;
					bc = 4'd8;
					ph = PH_RD_START;
					tm = load_ticks(cfg_q[REG_SLOT_START]);
				end
			endcase
		end

		if (ph != PH_IDLE) begin
			res.busy_res = 1'b1;
			// line drive for this tick
			case (ph)
				PH_RST_LOW, PH_WR_START, PH_RD_START: res.line_release = 1'b0;
				PH_WR_HOLD: res.line_release = sb[0];
				default: res.line_release = 1'b1;
			endcase

			// phase timer and transitions
			if (tm > TIMER_BITS'(1)) begin
				tm = tm - TIMER_BITS'(1);
			end else begin
				case (ph)
					PH_RST_LOW: begin
						ph = PH_RST_WAIT;
						tm = load_ticks(cfg_q[REG_PRESENCE_WAIT]);
					end
					PH_RST_WAIT: begin
						pres = item_s1.line_level;
						ph = PH_RST_TAIL;
						tm = load_ticks(cfg_q[REG_RESET_TAIL]);
					end
					PH_WR_START: begin
						ph = PH_WR_HOLD;
						tm = load_ticks(cfg_q[REG_WRITE_HOLD]);
					end
					PH_WR_HOLD: begin
						sb = {1'b0, sb[7:1]};
						bc = bc - 4'd1;
						if (bc == 4'd0) begin
							fin = 1'b1;
						end else begin
							ph = PH_WR_START;
							tm = load_ticks(cfg_q[REG_SLOT_START]);
						end
					end
					PH_RD_START: begin
						ph = PH_RD_WAIT;
						tm = load_ticks(cfg_q[REG_READ_SAMPLE]);
					end
					PH_RD_WAIT: begin
						if (aop == OP_READ_BYTE)
							sb = {item_s1.line_level, sb[7:1]};
						else
							sb = {7'd0, item_s1.line_level};
						ph = PH_RD_TAIL;
						tm = load_ticks(cfg_q[REG_READ_TAIL]);
					end
					PH_RD_TAIL: begin
						bc = bc - 4'd1;
						if (bc == 4'd0) begin
							fin = 1'b1;
						end else begin
							ph = PH_RD_START;
							tm = load_ticks(cfg_q[REG_SLOT_START]);
						end
					end
					default: fin = 1'b1;
				endcase

				// command finish
				if (fin) begin
					res.done_res = 1'b1;
					if (aop == OP_READ_BIT || aop == OP_READ_BYTE)
						res.read_byte = sb;
					ph = PH_IDLE;
					tm = '0;
				end
			end
		end
		res.presence_line = pres;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			bit_count_q <= '0;
			shift_q <= '0;
			op_q <= '0;
			presence_q <= 1'b1;
		end else if (advance) begin
			phase_q <= ph;
			timer_q <= tm;
			bit_count_q <= bc;
			shift_q <= sb;
			op_q <= aop;
			presence_q <= pres;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else if (advance)
			result_valid <= 1'b1;
		else if (result_ready)
			result_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			result <= res;
	end

	// checks
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.done_res |-> result.busy_res)
		else $error("done without busy");

	a_data_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.done_res |-> result.read_byte == 8'd0)
		else $error("read data outside finishing tick");

	a_idle_timer: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> timer_q == '0)
		else $error("timer running while idle");

	a_bit_count: assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q <= 4'd8)
		else $error("bit count out of range");

endmodule
`default_nettype wire
